// ===== design/pfrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrc_pkg: shared types and codes for the per-flow request counter table
// Holds the request and response words, the table entry layout and the
// status codes.
// ----------------------------------------------------------------------------
package pfrc_pkg;

  // Request word: command and flow key
  typedef struct packed {
    logic        cmd;
    logic [31:0] src_addr;
    logic [15:0] src_port_num;
  } in_word_t;

  // Response word: counter value and status
  typedef struct packed {
    logic [31:0] req_count;
    logic [2:0]  status;
  } out_word_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [31:0] key_addr;
    logic [15:0] key_port;
    logic [31:0] flow_count;
  } entry_t;

  // Commands
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Status codes
  localparam logic [2:0] ST_HIT           = 3'd0;
  localparam logic [2:0] ST_INSERTED      = 3'd1;
  localparam logic [2:0] ST_FULL          = 3'd2;
  localparam logic [2:0] ST_RESET_KNOWN   = 3'd3;
  localparam logic [2:0] ST_RESET_UNKNOWN = 3'd4;

endpackage

// ===== design/per_flow_request_counter_table.sv =====
// Throughput: one request at a time; req_ready is high only in idle. The walk
// reads one entry a cycle through the single read port of the table RAM.
// Reset clears the fill level, the sequencer and the response register; the
// table RAM is not cleared, since only entries below the fill level are read.
// ----------------------------------------------------------------------------
// per_flow_request_counter_table: exact-match flow table with counters
// Walks the filled entries for a matching key, then counts, resets or
// appends the flow and returns the counter value with a status code.
// ----------------------------------------------------------------------------
module per_flow_request_counter_table #(
  parameter int TABLE_ENTRIES = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  pfrc_pkg::in_word_t   req_word,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output pfrc_pkg::out_word_t  rsp_word
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = $bits(pfrc_pkg::entry_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]          state;
  pfrc_pkg::in_word_t  item;
  logic [FW-1:0]       rd_idx;
  logic                cmp_valid;
  logic [AW-1:0]       cmp_idx;
  logic [FW-1:0]       fill;
  pfrc_pkg::out_word_t res;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  pfrc_pkg::entry_t    wr_entry;
  logic [AW-1:0]       rd_addr;
  logic [EW-1:0]       rd_data;
  pfrc_pkg::entry_t    rd_entry;
  logic                hit;
  logic                walk_done;
  logic                issue;
  logic                has_room;
  logic [31:0]         count_inc;

  assign req_ready = (state == S_IDLE);
  assign rd_addr   = rd_idx[AW-1:0];
  assign rd_entry  = pfrc_pkg::entry_t'(rd_data);

  // Compare the entry read last cycle against the request key
  assign hit = (state == S_SCAN) && cmp_valid &&
               (rd_entry.key_addr == item.src_addr) &&
               (rd_entry.key_port == item.src_port_num);
  assign walk_done = (state == S_SCAN) && !hit && (rd_idx == fill);
  assign issue     = (state == S_SCAN) && !hit && (rd_idx != fill);
  assign has_room  = (fill < FW'(TABLE_ENTRIES));
  assign count_inc = rd_entry.flow_count + 32'd1;

  // Table write: update on a hit, append on a count miss with room
  always_comb begin
    wr_entry.key_addr = item.src_addr;
    wr_entry.key_port = item.src_port_num;
    if (hit) begin
      wr_en   = 1'b1;
      wr_addr = cmp_idx;
      wr_entry.flow_count = (item.cmd == pfrc_pkg::CMD_RESET) ? 32'd0 : count_inc;
    end else begin
      wr_en   = walk_done && (item.cmd == pfrc_pkg::CMD_COUNT) && has_room;
      wr_addr = fill[AW-1:0];
      wr_entry.flow_count = 32'd1;
    end
  end

  pfrc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (EW'(wr_entry)),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: take a word, walk the table, hand the result to the output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cmp_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item      <= req_word;
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance the read pointer and track the compare stage
          cmp_valid <= issue;
          cmp_idx   <= rd_addr;
          if (issue) begin
            rd_idx <= rd_idx + FW'(1);
          end
          if (hit) begin
            if (item.cmd == pfrc_pkg::CMD_RESET) begin
              res.req_count <= 32'd0;
              res.status    <= pfrc_pkg::ST_RESET_KNOWN;
            end else begin
              res.req_count <= count_inc;
              res.status    <= pfrc_pkg::ST_HIT;
            end
            state <= S_OUT;
          end else if (walk_done) begin
            if (item.cmd == pfrc_pkg::CMD_RESET) begin
              res.req_count <= 32'd0;
              res.status    <= pfrc_pkg::ST_RESET_UNKNOWN;
            end else if (has_room) begin
              res.req_count <= 32'd1;
              res.status    <= pfrc_pkg::ST_INSERTED;
              fill          <= fill + FW'(1);
            end else begin
              res.req_count <= 32'd1;
              res.status    <= pfrc_pkg::ST_FULL;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!rsp_valid || rsp_ready) begin
            rsp_word  <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/pfrc_ram.sv =====
// ----------------------------------------------------------------------------
// pfrc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfrc_ram #(
  parameter int WIDTH  = 80,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/pfrc_checker.sv =====
// ----------------------------------------------------------------------------
// pfrc_checker: port-level checks for the per-flow request counter table
// Watches the response channel and the status/count pairing.
// ----------------------------------------------------------------------------
module pfrc_checker (
  input logic                clk,
  input logic                rst,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input pfrc_pkg::out_word_t rsp_word
);

  // Hold a stalled response word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
    else $error("response word dropped or changed while stalled");

  // Reset requests always return zero
  a_reset_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.status == pfrc_pkg::ST_RESET_KNOWN ||
                  rsp_word.status == pfrc_pkg::ST_RESET_UNKNOWN)
    |-> rsp_word.req_count == 32'd0)
    else $error("reset response with nonzero count");

  // Inserts and untracked flows return one
  a_new_one: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_word.status == pfrc_pkg::ST_INSERTED ||
                  rsp_word.status == pfrc_pkg::ST_FULL)
    |-> rsp_word.req_count == 32'd1)
    else $error("insert or full response with count other than one");

  // Status stays within the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_word.status <= pfrc_pkg::ST_RESET_UNKNOWN)
    else $error("undefined status code");

  // Drop any response after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

endmodule

bind per_flow_request_counter_table pfrc_checker u_pfrc_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_word  (rsp_word)
);

// ===== tb/tb_per_flow_request_counter_table.sv =====
// ----------------------------------------------------------------------------
// tb_per_flow_request_counter_table: self-checking bench for the flow table
// Drives count and reset requests over valid/ready, predicts each response
// word from a private copy of the flow table, and compares it field by
// field. A short directed part hits the key extremes and every status but full, then
// a random part fills the table to full with mostly hits and near-miss keys.
// ----------------------------------------------------------------------------
module tb_per_flow_request_counter_table;

  localparam int ENTRIES      = 128;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_TAIL   = 120;

  // Predict response words from a private copy of the flow table
  class flow_counter_tracker;
    bit [31:0]           key_addr [ENTRIES];
    bit [15:0]           key_port [ENTRIES];
    bit [31:0]           flow_count [ENTRIES];
    int unsigned         fill = 0;
    pfrc_pkg::out_word_t awaited_words[$];
    int unsigned         errors = 0;
    int unsigned         requests = 0;
    int unsigned         responses = 0;
    int unsigned         status_seen [8];

    task report(input string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Walk the filled entries, then count, reset or append the flow
    task note_request(input pfrc_pkg::in_word_t w);
      pfrc_pkg::out_word_t exp;
      int                  hit_idx;
      hit_idx = -1;
      for (int i = 0; i < fill; i++) begin
        if (key_addr[i] == w.src_addr && key_port[i] == w.src_port_num) begin
          hit_idx = i;
          break;
        end
      end
      if (hit_idx >= 0) begin
        if (w.cmd == pfrc_pkg::CMD_RESET) begin
          flow_count[hit_idx] = '0;
          exp.req_count = '0;
          exp.status    = pfrc_pkg::ST_RESET_KNOWN;
        end else begin
          flow_count[hit_idx] = flow_count[hit_idx] + 32'd1;
          exp.req_count = flow_count[hit_idx];
          exp.status    = pfrc_pkg::ST_HIT;
        end
      end else if (w.cmd == pfrc_pkg::CMD_RESET) begin
        exp.req_count = '0;
        exp.status    = pfrc_pkg::ST_RESET_UNKNOWN;
      end else if (fill < ENTRIES) begin
        key_addr[fill]   = w.src_addr;
        key_port[fill]   = w.src_port_num;
        flow_count[fill] = 32'd1;
        fill++;
        exp.req_count = 32'd1;
        exp.status    = pfrc_pkg::ST_INSERTED;
      end else begin
        exp.req_count = 32'd1;
        exp.status    = pfrc_pkg::ST_FULL;
      end
      awaited_words.push_back(exp);
      requests++;
    endtask

    // Compare one response word with the oldest prediction
    task check_response(input pfrc_pkg::out_word_t got);
      pfrc_pkg::out_word_t exp;
      if (awaited_words.size() == 0) begin
        report($sformatf("unexpected response count %0d status %0d",
                         got.req_count, got.status));
        return;
      end
      exp = awaited_words.pop_front();
      responses++;
      status_seen[exp.status]++;
      if (got.req_count !== exp.req_count)
        report($sformatf("response %0d req_count %0d, predicted %0d",
                         responses, got.req_count, exp.req_count));
      if (got.status !== exp.status)
        report($sformatf("response %0d status %0d, predicted %0d",
                         responses, got.status, exp.status));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                req_valid;
  logic                req_ready;
  pfrc_pkg::in_word_t  req_word;
  logic                rsp_valid;
  logic                rsp_ready;
  pfrc_pkg::out_word_t rsp_word;

  flow_counter_tracker tracker;
  int unsigned         gap_pct   = 20;
  int unsigned         stall_pct = 20;

  per_flow_request_counter_table #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Note accepted requests and check accepted responses
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) tracker.note_request(req_word);
      if (rsp_valid && rsp_ready) tracker.check_response(rsp_word);
    end
  end

  // Stall the response side in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    rsp_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else if (rsp_ready && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_ready  <= 1'b0;
        stall_left = $urandom_range(1, 4) - 1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic pfrc_pkg::in_word_t make_word(input logic cmd,
                                                   input logic [31:0] addr,
                                                   input logic [15:0] port);
    pfrc_pkg::in_word_t w;
    w.cmd          = cmd;
    w.src_addr     = addr;
    w.src_port_num = port;
    return w;
  endfunction

  // Hold one request word until accepted, after an optional idle burst
  task automatic send_word(input pfrc_pkg::in_word_t w);
    int unsigned gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 4);
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= w;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Mostly known flows and near misses, some fresh keys and resets
  function automatic pfrc_pkg::in_word_t pick_request();
    pfrc_pkg::in_word_t w;
    int unsigned        roll;
    int unsigned        idx;
    roll = $urandom_range(0, 99);
    w = make_word(pfrc_pkg::CMD_COUNT, $urandom, 16'($urandom_range(0, 65535)));
    if (tracker.fill == 0) return w;
    idx = $urandom_range(0, tracker.fill - 1);
    if (roll < 15) begin
      // fresh random key
    end else if (roll < 30) begin
      // flip one key bit of a known flow
      w.src_addr     = tracker.key_addr[idx];
      w.src_port_num = tracker.key_port[idx];
      if ($urandom_range(0, 1) == 0)
        w.src_addr = w.src_addr ^ (32'd1 << $urandom_range(0, 31));
      else
        w.src_port_num = w.src_port_num ^ (16'd1 << $urandom_range(0, 15));
      w.cmd = ($urandom_range(0, 3) == 0) ? pfrc_pkg::CMD_RESET : pfrc_pkg::CMD_COUNT;
    end else if (roll < 82) begin
      // count or reset a known flow, now and then the deepest entry
      if (roll >= 74) idx = tracker.fill - 1;
      w.src_addr     = tracker.key_addr[idx];
      w.src_port_num = tracker.key_port[idx];
      w.cmd          = (roll >= 62 && roll < 74) ? pfrc_pkg::CMD_RESET : pfrc_pkg::CMD_COUNT;
    end else begin
      w.cmd = ($urandom_range(0, 1) == 0) ? pfrc_pkg::CMD_RESET : pfrc_pkg::CMD_COUNT;
    end
    return w;
  endfunction

  initial begin
    int unsigned pct_choice [3];
    pct_choice = '{0, 15, 35};
    tracker    = new();
    rst        = 1'b1;
    req_valid  = 1'b0;
    req_word   = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: key extremes, every status but full, reset then count.
    // Counter wrap needs 2^32 counts on one flow and stays out of reach.
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h0000_0000, 16'h0000));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h0000_0000, 16'h0000));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 16'h0000));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h0000_0000, 16'hFFFF));
    send_word(make_word(pfrc_pkg::CMD_RESET, 32'h0000_0000, 16'h0000));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h0000_0000, 16'h0000));
    send_word(make_word(pfrc_pkg::CMD_RESET, 32'h1234_5678, 16'h0001));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h1234_5678, 16'h0001));
    send_word(make_word(pfrc_pkg::CMD_RESET, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(pfrc_pkg::CMD_RESET, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'hFFFF_FFFF, 16'hFFFF));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'hAAAA_AAAA, 16'h5555));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h5555_5555, 16'hAAAA));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'hAAAA_AAAA, 16'hAAAA));
    send_word(make_word(pfrc_pkg::CMD_COUNT, 32'h5555_5555, 16'hAAAA));
    send_word(make_word(pfrc_pkg::CMD_RESET, 32'h8000_0000, 16'h8000));

    // Random: vary idling per segment, none in the tail
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (n % 40 == 0) begin
        gap_pct   = pct_choice[$urandom_range(0, 2)];
        stall_pct = pct_choice[$urandom_range(0, 2)];
      end
      send_word(pick_request());
    end
    req_valid <= 1'b0;

    // Drain outstanding responses, then allow one full walk
    while (tracker.awaited_words.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (tracker.awaited_words.size() != 0)
      tracker.report($sformatf("%0d responses never arrived",
                               tracker.awaited_words.size()));

    $display("Sent %0d requests, checked %0d responses, table holds %0d of %0d flows",
             tracker.requests, tracker.responses, tracker.fill, ENTRIES);
    $display("Statuses: hit %0d, inserted %0d, full %0d, reset known %0d, reset unknown %0d",
             tracker.status_seen[pfrc_pkg::ST_HIT],
             tracker.status_seen[pfrc_pkg::ST_INSERTED],
             tracker.status_seen[pfrc_pkg::ST_FULL],
             tracker.status_seen[pfrc_pkg::ST_RESET_KNOWN],
             tracker.status_seen[pfrc_pkg::ST_RESET_UNKNOWN]);
    if (tracker.errors == 0) begin
      $display("per_flow_request_counter_table regression: pass");
    end else begin
      $display("per_flow_request_counter_table regression: fail");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #10_000_000;
    $display("per_flow_request_counter_table regression: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
design/pfrc_pkg.sv
design/pfrc_ram.sv
design/per_flow_request_counter_table.sv
design/pfrc_checker.sv
tb/tb_per_flow_request_counter_table.sv
